/* src/qolm_pkg.sv */
// Shared types, constants and the step program of the quadrotor observer and LQR mixer.
`timescale 1ns / 1ps
package qolm_pkg;

  // Default number of fractional bits of the state and I/O values.
  localparam int FRAC_BITS_DEF = 16;

  // Widths of the datapath.
  localparam int VAL_W   = 32;
  localparam int OPND_W  = 33;
  localparam int COEF_W  = 32;
  localparam int ACC_W   = 64;
  localparam int MOT_W   = 16;

  // Observer products are Q30 constants; results are rounded half up at bit 30.
  localparam int OBS_SHIFT = 30;

  // Scale of the observer constants and of the mixer constants.
  localparam longint Q30_SCALE = 64'sd1073741824;
  localparam longint E9        = 64'sd1000000000;
  localparam longint E9_HALF   = 64'sd500000000;

  // Observer constants: dt, dt*9.81, pi/180 and dt times each observer gain, in Q30.
  localparam longint C_DT  = (64'sd2000000 * Q30_SCALE + E9_HALF) / E9;
  localparam longint C_DTG = (64'sd19620000 * Q30_SCALE + E9_HALF) / E9;
  localparam longint C_D2R = (64'sd17453293 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_OX  = (64'sd35516364 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_OY  = (64'sd35444624 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_OZ  = (64'sd42860238 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_TH  = (64'sd68666667 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_PH  = (64'sd101500000 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_VX  = (64'sd240241914 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_VY  = (64'sd271830348 * Q30_SCALE + E9_HALF) / E9;
  localparam longint K_VZ  = (64'sd187000000 * Q30_SCALE + E9_HALF) / E9;

  // Mixer gains in units of 0.1.
  localparam longint MA = 64'sd34965310;
  localparam longint MB = 64'sd411098107;
  localparam longint MC = 64'sd1223786;

  // LQR gain times mixer gain, in Q8.
  localparam longint X_EY  = (64'sd118322 * MA * 256 + E9_HALF) / E9;
  localparam longint X_PHI = (64'sd499485 * MA * 256 + E9_HALF) / E9;
  localparam longint X_VY  = (64'sd141594 * MA * 256 + E9_HALF) / E9;
  localparam longint X_WX  = (64'sd89651 * MA * 256 + E9_HALF) / E9;
  localparam longint Y_EX  = (64'sd173205 * MA * 256 + E9_HALF) / E9;
  localparam longint Y_TH  = (64'sd623766 * MA * 256 + E9_HALF) / E9;
  localparam longint Y_VX  = (64'sd189279 * MA * 256 + E9_HALF) / E9;
  localparam longint Y_WY  = (64'sd99107 * MA * 256 + E9_HALF) / E9;
  localparam longint Z_PSI = (64'sd160000 * MB * 256 + E9_HALF) / E9;
  localparam longint Z_WZ  = (64'sd175942 * MB * 256 + E9_HALF) / E9;
  localparam longint F_EZ  = (64'sd6324555 * MC * 256 + E9_HALF) / E9;
  localparam longint F_VZ  = (64'sd7349171 * MC * 256 + E9_HALF) / E9;
  localparam longint F_K   = (64'sd35217900 * MC * 256 + E9_HALF) / E9;

  // Sign markers for steps that pass a stored sum instead of multiplying.
  localparam longint COEF_POS = 64'sd1;
  localparam longint COEF_NEG = -64'sd1;

  // Length of the step program and width of the step counter.
  localparam int NSTEP = 50;
  localparam int CNT_W = $clog2(NSTEP + 2);

  // Operand that a step feeds to the multiplier.
  typedef enum logic [4:0] {
    OP_GYRO_X, OP_GYRO_Y, OP_GYRO_Z, OP_ACCEL_Z, OP_ONE,
    OP_EX, OP_EY, OP_EZ,
    OP_VEL_X, OP_VEL_Y, OP_VEL_Z,
    OP_W_X, OP_W_Y, OP_W_Z,
    OP_YAW, OP_PITCH, OP_ROLL,
    OP_DPOS_X, OP_DPOS_Y, OP_DPOS_Z,
    OP_PX, OP_PY, OP_PZ, OP_PF
  } opnd_t;

  // Register that receives the finished sum of a group of steps.
  typedef enum logic [4:0] {
    DST_WX, DST_WY, DST_WZ,
    DST_POS_X, DST_POS_Y, DST_POS_Z,
    DST_YAW, DST_PITCH, DST_ROLL,
    DST_VEL_X, DST_VEL_Y, DST_VEL_Z,
    DST_PX, DST_PY, DST_PZ, DST_PF,
    DST_M1, DST_M2, DST_M3, DST_M4
  } dst_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // One entry of the step program.
  typedef struct packed {
    opnd_t                     opnd;
    logic signed [COEF_W-1:0]  coef;
    logic                      first;
    logic                      last;
    dst_t                      dst;
  } step_t;

  // Control from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic pass;
    dst_t dst;
  } mac_ctl_t;

  // Writeback request from the arithmetic unit.
  typedef struct packed {
    logic valid;
    dst_t dst;
  } mac_wb_t;

  // Builds one step entry.
  function automatic step_t mk(opnd_t op, longint c, logic f, logic l, dst_t d);
    step_t s;
    s.opnd  = op;
    s.coef  = COEF_W'(c);
    s.first = f;
    s.last  = l;
    s.dst   = d;
    return s;
  endfunction

  // Step program: gyro conversion, observer update, LQR sums, then motor sums.
  // Each consumer of a freshly written value sits at least three steps after
  // the last step of the group that writes it.
  function automatic step_t step_of(logic [CNT_W-1:0] idx);
    step_t s;
    case (idx)
      6'd0:  s = mk(OP_GYRO_X, C_D2R, 1'b1, 1'b1, DST_WX);
      6'd1:  s = mk(OP_GYRO_Y, C_D2R, 1'b1, 1'b1, DST_WY);
      6'd2:  s = mk(OP_GYRO_Z, C_D2R, 1'b1, 1'b1, DST_WZ);
      6'd3:  s = mk(OP_VEL_X, C_DT, 1'b1, 1'b0, DST_POS_X);
      6'd4:  s = mk(OP_EX, -K_OX, 1'b0, 1'b1, DST_POS_X);
      6'd5:  s = mk(OP_VEL_Y, C_DT, 1'b1, 1'b0, DST_POS_Y);
      6'd6:  s = mk(OP_EY, -K_OY, 1'b0, 1'b1, DST_POS_Y);
      6'd7:  s = mk(OP_VEL_Z, C_DT, 1'b1, 1'b0, DST_POS_Z);
      6'd8:  s = mk(OP_EZ, -K_OZ, 1'b0, 1'b1, DST_POS_Z);
      6'd9:  s = mk(OP_W_Z, C_DT, 1'b1, 1'b1, DST_YAW);
      6'd10: s = mk(OP_W_Y, C_DT, 1'b1, 1'b0, DST_PITCH);
      6'd11: s = mk(OP_EX, -K_TH, 1'b0, 1'b1, DST_PITCH);
      6'd12: s = mk(OP_W_X, C_DT, 1'b1, 1'b0, DST_ROLL);
      6'd13: s = mk(OP_EY, K_PH, 1'b0, 1'b1, DST_ROLL);
      6'd14: s = mk(OP_PITCH, C_DTG, 1'b1, 1'b0, DST_VEL_X);
      6'd15: s = mk(OP_EX, -K_VX, 1'b0, 1'b1, DST_VEL_X);
      6'd16: s = mk(OP_ROLL, -C_DTG, 1'b1, 1'b0, DST_VEL_Y);
      6'd17: s = mk(OP_EY, -K_VY, 1'b0, 1'b1, DST_VEL_Y);
      6'd18: s = mk(OP_ACCEL_Z, C_DTG, 1'b1, 1'b0, DST_VEL_Z);
      6'd19: s = mk(OP_ONE, -C_DTG, 1'b0, 1'b0, DST_VEL_Z);
      6'd20: s = mk(OP_EZ, -K_VZ, 1'b0, 1'b1, DST_VEL_Z);
      6'd21: s = mk(OP_DPOS_Y, X_EY, 1'b1, 1'b0, DST_PX);
      6'd22: s = mk(OP_ROLL, -X_PHI, 1'b0, 1'b0, DST_PX);
      6'd23: s = mk(OP_VEL_Y, X_VY, 1'b0, 1'b0, DST_PX);
      6'd24: s = mk(OP_W_X, -X_WX, 1'b0, 1'b1, DST_PX);
      6'd25: s = mk(OP_DPOS_X, -Y_EX, 1'b1, 1'b0, DST_PY);
      6'd26: s = mk(OP_PITCH, -Y_TH, 1'b0, 1'b0, DST_PY);
      6'd27: s = mk(OP_VEL_X, -Y_VX, 1'b0, 1'b0, DST_PY);
      6'd28: s = mk(OP_W_Y, -Y_WY, 1'b0, 1'b1, DST_PY);
      6'd29: s = mk(OP_YAW, -Z_PSI, 1'b1, 1'b0, DST_PZ);
      6'd30: s = mk(OP_W_Z, -Z_WZ, 1'b0, 1'b1, DST_PZ);
      6'd31: s = mk(OP_DPOS_Z, -F_EZ, 1'b1, 1'b0, DST_PF);
      6'd32: s = mk(OP_VEL_Z, -F_VZ, 1'b0, 1'b0, DST_PF);
      6'd33: s = mk(OP_ONE, F_K, 1'b0, 1'b1, DST_PF);
      6'd34: s = mk(OP_PX, COEF_NEG, 1'b1, 1'b0, DST_M1);
      6'd35: s = mk(OP_PY, COEF_NEG, 1'b0, 1'b0, DST_M1);
      6'd36: s = mk(OP_PZ, COEF_NEG, 1'b0, 1'b0, DST_M1);
      6'd37: s = mk(OP_PF, COEF_POS, 1'b0, 1'b1, DST_M1);
      6'd38: s = mk(OP_PX, COEF_NEG, 1'b1, 1'b0, DST_M2);
      6'd39: s = mk(OP_PY, COEF_POS, 1'b0, 1'b0, DST_M2);
      6'd40: s = mk(OP_PZ, COEF_POS, 1'b0, 1'b0, DST_M2);
      6'd41: s = mk(OP_PF, COEF_POS, 1'b0, 1'b1, DST_M2);
      6'd42: s = mk(OP_PX, COEF_POS, 1'b1, 1'b0, DST_M3);
      6'd43: s = mk(OP_PY, COEF_POS, 1'b0, 1'b0, DST_M3);
      6'd44: s = mk(OP_PZ, COEF_NEG, 1'b0, 1'b0, DST_M3);
      6'd45: s = mk(OP_PF, COEF_POS, 1'b0, 1'b1, DST_M3);
      6'd46: s = mk(OP_PX, COEF_POS, 1'b1, 1'b0, DST_M4);
      6'd47: s = mk(OP_PY, COEF_NEG, 1'b0, 1'b0, DST_M4);
      6'd48: s = mk(OP_PZ, COEF_POS, 1'b0, 1'b0, DST_M4);
      6'd49: s = mk(OP_PF, COEF_POS, 1'b0, 1'b1, DST_M4);
      default: s = mk(OP_ONE, COEF_POS, 1'b0, 1'b0, DST_M4);
    endcase
    return s;
  endfunction

endpackage

/* src/qolm_mac.sv */
// Shared multiply-accumulate unit; rounds and saturates finished observer and motor sums.
`timescale 1ns / 1ps
module qolm_mac #(
  parameter int FRAC_BITS = qolm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  qolm_pkg::mac_ctl_t                    ctl,
  input  logic signed [qolm_pkg::OPND_W-1:0]    opnd,
  input  logic signed [qolm_pkg::COEF_W-1:0]    coef,
  input  logic signed [qolm_pkg::ACC_W-1:0]     pass_val,
  input  logic signed [qolm_pkg::VAL_W-1:0]     base,
  output qolm_pkg::mac_wb_t                     wb,
  output logic signed [qolm_pkg::ACC_W-1:0]     acc,
  output logic signed [qolm_pkg::VAL_W-1:0]     obs_res,
  output logic [qolm_pkg::MOT_W-1:0]            mot_res
);
  import qolm_pkg::*;

  localparam int MOT_SHIFT = FRAC_BITS + 8;
  localparam logic signed [ACC_W-1:0] OBS_BIAS = ACC_W'(64'sd1 <<< (OBS_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] MOT_BIAS = ACC_W'(64'sd1 <<< (MOT_SHIFT - 1));
  localparam logic signed [VAL_W+2:0] SAT_HI = (VAL_W+3)'(64'sd2147483647);
  localparam logic signed [VAL_W+2:0] SAT_LO = (VAL_W+3)'(-64'sd2147483648);

  logic signed [OPND_W+COEF_W-1:0] mul_full;
  logic signed [ACC_W-1:0]         prod;
  logic signed [ACC_W-1:0]         prod_next;
  mac_ctl_t                        s1;
  mac_wb_t                         s2;
  logic signed [ACC_W-1:0]         bias;
  logic signed [ACC_W-1:0]         acc_in;
  logic signed [ACC_W-1:0]         rnd;
  logic signed [VAL_W+2:0]         obs_sum;
  logic signed [ACC_W-1:0]         mshift;

  // Product stage: one multiplier, or a signed pass of a stored sum.
  assign mul_full = opnd * coef;

  always_comb begin
    if (ctl.pass) begin
      prod_next = coef[COEF_W-1] ? -pass_val : pass_val;
    end else begin
      prod_next = mul_full[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s1.first <= 1'b0;
      s1.last  <= 1'b0;
      s1.pass  <= 1'b0;
      s1.dst   <= DST_WX;
    end else begin
      s1 <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  // Rounding bias that a group's first step loads with its product.
  always_comb begin
    case (s1.dst)
      DST_PX, DST_PY, DST_PZ, DST_PF: bias = '0;
      DST_M1, DST_M2, DST_M3, DST_M4: bias = MOT_BIAS;
      default:                        bias = OBS_BIAS;
    endcase
  end

  assign acc_in = s1.first ? bias : acc;

  // Accumulate stage.
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      acc <= acc_in + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s2.dst   <= DST_WX;
    end else begin
      s2.valid <= s1.valid & s1.last;
      s2.dst   <= s1.dst;
    end
  end

  assign wb = s2;

  // Observer result: drop the Q30 fraction, add the old state and saturate.
  always_comb begin
    rnd     = acc >>> OBS_SHIFT;
    obs_sum = {rnd[VAL_W+1], rnd[VAL_W+1:0]} + {{3{base[VAL_W-1]}}, base};
    if (obs_sum > SAT_HI) begin
      obs_res = VAL_W'(SAT_HI);
    end else if (obs_sum < SAT_LO) begin
      obs_res = VAL_W'(SAT_LO);
    end else begin
      obs_res = obs_sum[VAL_W-1:0];
    end
  end

  // Motor result: integer part of the biased sum, clamped to the command range.
  always_comb begin
    mshift = acc >>> MOT_SHIFT;
    if (mshift < 0) begin
      mot_res = '0;
    end else if (mshift > ACC_W'(64'sd65535)) begin
      mot_res = '1;
    end else begin
      mot_res = mshift[MOT_W-1:0];
    end
  end

endmodule

/* src/quadrotor_observer_lqr_mixer.sv */
// Top level of the quadrotor observer, LQR law and motor mixer.
//
// One request on the input stream is one control tick: the position setpoint,
// gyro rates, vertical acceleration, position measurement and two flags. The
// block runs a fixed 50-step program on one 33x32 multiplier and one 64-bit
// accumulator: gyro conversion, the nine-state observer update, the four LQR
// sums and the four motor sums. The result is loaded into the output register
// at the same edge at which the input becomes ready again; while the output
// register still holds an untaken result, the block waits before it returns
// to idle. The input is not ready while a tick is in work. All four motor
// commands are zero when the motors are disabled; the observer updates anyway.
`timescale 1ns / 1ps
module quadrotor_observer_lqr_mixer #(
  parameter int FRAC_BITS = qolm_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // des_x, des_y, des_z, gyro_x, gyro_y, gyro_z, accel_z, meas_x, meas_y, meas_z
  input  logic [319:0] s_tdata,
  // motors_enabled, clear_estimate
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // motor_1, motor_2, motor_3, motor_4
  output logic [63:0]  m_tdata
);
  import qolm_pkg::*;

  localparam logic signed [OPND_W-1:0] ONE_VAL = OPND_W'(64'sd1 <<< FRAC_BITS);

  state_t state;
  state_t state_next;
  logic [CNT_W-1:0] cnt;

  // Latched tick inputs.
  logic signed [VAL_W-1:0] des_x, des_y, des_z;
  logic signed [VAL_W-1:0] gyro_x, gyro_y, gyro_z, accel_z;
  logic                    motors_enabled;

  // Position errors against the pre-update estimate.
  logic signed [OPND_W-1:0] ex, ey, ez;

  // Observer state.
  logic signed [VAL_W-1:0] est_pos_x, est_pos_y, est_pos_z;
  logic signed [VAL_W-1:0] est_yaw, est_pitch, est_roll;
  logic signed [VAL_W-1:0] est_vel_x, est_vel_y, est_vel_z;

  // Intermediate results.
  logic signed [VAL_W-1:0] w_x, w_y, w_z;
  logic signed [ACC_W-1:0] p_x, p_y, p_z, p_f;
  logic [MOT_W-1:0]        mot1, mot2, mot3, mot4;

  logic                     accept;
  logic                     issue;
  logic                     run_done;
  logic                     out_free;
  logic                     load_out;
  logic                     clear;
  step_t                    step;
  mac_ctl_t                 ctl;
  mac_wb_t                  wb;
  logic signed [OPND_W-1:0] opnd;
  logic signed [ACC_W-1:0]  pass_val;
  logic                     pass;
  logic signed [VAL_W-1:0]  base;
  logic signed [ACC_W-1:0]  acc;
  logic signed [VAL_W-1:0]  obs_res;
  logic [MOT_W-1:0]         mot_res;

  assign accept   = s_tvalid & s_tready;
  assign clear    = s_tuser[1];
  assign run_done = (cnt == CNT_W'(NSTEP + 1));
  assign out_free = ~m_tvalid | m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_RUN:  issue    = (cnt < CNT_W'(NSTEP));
      ST_FIN:  load_out = out_free;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Latch the tick and form the position errors.
  always_ff @(posedge clk) begin
    if (accept) begin
      des_x          <= s_tdata[31:0];
      des_y          <= s_tdata[63:32];
      des_z          <= s_tdata[95:64];
      gyro_x         <= s_tdata[127:96];
      gyro_y         <= s_tdata[159:128];
      gyro_z         <= s_tdata[191:160];
      accel_z        <= s_tdata[223:192];
      motors_enabled <= s_tuser[0];
      ex <= (clear ? '0 : {est_pos_x[VAL_W-1], est_pos_x})
            - {s_tdata[255], s_tdata[255:224]};
      ey <= (clear ? '0 : {est_pos_y[VAL_W-1], est_pos_y})
            - {s_tdata[287], s_tdata[287:256]};
      ez <= (clear ? '0 : {est_pos_z[VAL_W-1], est_pos_z})
            - {s_tdata[319], s_tdata[319:288]};
    end
  end

  // Step fetch and operand selection.
  assign step = step_of(cnt);

  always_comb begin
    opnd     = '0;
    pass     = 1'b0;
    pass_val = '0;
    case (step.opnd)
      OP_GYRO_X:  opnd = {gyro_x[VAL_W-1], gyro_x};
      OP_GYRO_Y:  opnd = {gyro_y[VAL_W-1], gyro_y};
      OP_GYRO_Z:  opnd = {gyro_z[VAL_W-1], gyro_z};
      OP_ACCEL_Z: opnd = {accel_z[VAL_W-1], accel_z};
      OP_ONE:     opnd = ONE_VAL;
      OP_EX:      opnd = ex;
      OP_EY:      opnd = ey;
      OP_EZ:      opnd = ez;
      OP_VEL_X:   opnd = {est_vel_x[VAL_W-1], est_vel_x};
      OP_VEL_Y:   opnd = {est_vel_y[VAL_W-1], est_vel_y};
      OP_VEL_Z:   opnd = {est_vel_z[VAL_W-1], est_vel_z};
      OP_W_X:     opnd = {w_x[VAL_W-1], w_x};
      OP_W_Y:     opnd = {w_y[VAL_W-1], w_y};
      OP_W_Z:     opnd = {w_z[VAL_W-1], w_z};
      OP_YAW:     opnd = {est_yaw[VAL_W-1], est_yaw};
      OP_PITCH:   opnd = {est_pitch[VAL_W-1], est_pitch};
      OP_ROLL:    opnd = {est_roll[VAL_W-1], est_roll};
      OP_DPOS_X:  opnd = {est_pos_x[VAL_W-1], est_pos_x} - {des_x[VAL_W-1], des_x};
      OP_DPOS_Y:  opnd = {est_pos_y[VAL_W-1], est_pos_y} - {des_y[VAL_W-1], des_y};
      OP_DPOS_Z:  opnd = {est_pos_z[VAL_W-1], est_pos_z} - {des_z[VAL_W-1], des_z};
      OP_PX: begin
        pass     = 1'b1;
        pass_val = p_x;
      end
      OP_PY: begin
        pass     = 1'b1;
        pass_val = p_y;
      end
      OP_PZ: begin
        pass     = 1'b1;
        pass_val = p_z;
      end
      OP_PF: begin
        pass     = 1'b1;
        pass_val = p_f;
      end
      default: opnd = '0;
    endcase
  end

  always_comb begin
    ctl.valid = issue;
    ctl.first = step.first;
    ctl.last  = step.last;
    ctl.pass  = pass;
    ctl.dst   = step.dst;
  end

  qolm_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .opnd     (opnd),
    .coef     (step.coef),
    .pass_val (pass_val),
    .base     (base),
    .wb       (wb),
    .acc      (acc),
    .obs_res  (obs_res),
    .mot_res  (mot_res)
  );

  // Old value of the state that a finished observer sum is added to.
  always_comb begin
    case (wb.dst)
      DST_POS_X: base = est_pos_x;
      DST_POS_Y: base = est_pos_y;
      DST_POS_Z: base = est_pos_z;
      DST_YAW:   base = est_yaw;
      DST_PITCH: base = est_pitch;
      DST_ROLL:  base = est_roll;
      DST_VEL_X: base = est_vel_x;
      DST_VEL_Y: base = est_vel_y;
      DST_VEL_Z: base = est_vel_z;
      default:   base = '0;
    endcase
  end

  // Observer state: cleared on reset or on request, then written back.
  always_ff @(posedge clk) begin
    if (rst || (accept && clear)) begin
      est_pos_x <= '0;
      est_pos_y <= '0;
      est_pos_z <= '0;
      est_yaw   <= '0;
      est_pitch <= '0;
      est_roll  <= '0;
      est_vel_x <= '0;
      est_vel_y <= '0;
      est_vel_z <= '0;
    end else if (wb.valid) begin
      case (wb.dst)
        DST_POS_X: est_pos_x <= obs_res;
        DST_POS_Y: est_pos_y <= obs_res;
        DST_POS_Z: est_pos_z <= obs_res;
        DST_YAW:   est_yaw   <= obs_res;
        DST_PITCH: est_pitch <= obs_res;
        DST_ROLL:  est_roll  <= obs_res;
        DST_VEL_X: est_vel_x <= obs_res;
        DST_VEL_Y: est_vel_y <= obs_res;
        DST_VEL_Z: est_vel_z <= obs_res;
        default:   est_pos_x <= est_pos_x;
      endcase
    end
  end

  // Writeback of rates, LQR sums and motor commands.
  always_ff @(posedge clk) begin
    if (wb.valid) begin
      case (wb.dst)
        DST_WX:  w_x  <= obs_res;
        DST_WY:  w_y  <= obs_res;
        DST_WZ:  w_z  <= obs_res;
        DST_PX:  p_x  <= acc;
        DST_PY:  p_y  <= acc;
        DST_PZ:  p_z  <= acc;
        DST_PF:  p_f  <= acc;
        DST_M1:  mot1 <= mot_res;
        DST_M2:  mot2 <= mot_res;
        DST_M3:  mot3 <= mot_res;
        DST_M4:  mot4 <= mot_res;
        default: w_x  <= w_x;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= motors_enabled ? {mot4, mot3, mot2, mot1} : '0;
    end
  end

endmodule
